@@ rtl/vertex_weld_hash_remap_unit_defines.svh @@
// Assertion macros for the vertex weld unit.
// Expects clk_i and rst_ni in the scope of use.
`ifndef VERTEX_WELD_HASH_REMAP_UNIT_DEFINES_SVH
`define VERTEX_WELD_HASH_REMAP_UNIT_DEFINES_SVH

// same-cycle implication
`define VWHR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VWHR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/vwhr_pkg.sv @@
// Shared types and constants for the vertex weld unit.
// No dependencies.
package vwhr_pkg;

  localparam logic [1:0] MODE_VERTEX   = 2'd0;
  localparam logic [1:0] MODE_TRIANGLE = 2'd1;
  localparam logic [1:0] MODE_START    = 2'd2;
  localparam logic [1:0] MODE_NOP      = 2'd3;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_FULL   = 2'd1;
  localparam logic [1:0] ERR_UNSEEN = 2'd2;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_TRI    = 1'b1;

  localparam logic [31:0] HASH_KX  = 32'd2654435761;
  localparam logic [31:0] HASH_KY  = 32'd2246822519;
  localparam logic [31:0] HASH_KZ  = 32'd3266489917;
  localparam logic [31:0] HASH_FIN = 32'h85EBCA6B;

  typedef struct packed {
    logic        go;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } hash_req_t;

endpackage

@@ rtl/vwhr_if.sv @@
// Beat channels of the vertex weld unit: input items and results.
// No dependencies.
interface vwhr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] cell_x;
  logic signed [31:0] cell_y;
  logic signed [31:0] cell_z;
  logic [13:0]        old_a;
  logic [13:0]        old_b;
  logic [13:0]        old_c;
  modport source (output valid, mode, cell_x, cell_y, cell_z, old_a, old_b, old_c,
                  input ready);
  modport sink (input valid, mode, cell_x, cell_y, cell_z, old_a, old_b, old_c,
                output ready);
endinterface

interface vwhr_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [13:0] new_index;
  logic        is_new;
  logic [13:0] tri_a;
  logic [13:0] tri_b;
  logic [13:0] tri_c;
  logic [1:0]  error;
  modport source (output valid, result_kind, new_index, is_new, tri_a, tri_b, tri_c, error,
                  input ready);
  modport sink (input valid, result_kind, new_index, is_new, tri_a, tri_b, tri_c, error,
                output ready);
endinterface

@@ rtl/vertex_weld_hash_remap_unit.sv @@
// Vertex weld unit top: hash table probe, remap store, triangle remap.
// Depends on vwhr_pkg, vwhr_if, vwhr_hash and the defines header.
//
//  channel | dir | beat contents
//  in_i    | in  | mode, cell_x/y/z (vertex), old_a/b/c (triangle)
//  out_o   | out | result_kind, new_index, is_new, tri_a/b/c, error
//
// Steps: a vertex is hashed in 4 hash stages, then one read and one check of
//   the slot memory follow; each further probed slot adds another read and
//   check. A triangle does three reads of the remap memory, and a triangle that
//   is dropped gives no result. Items rejected at accept (capacity full, unseen
//   corner) go straight to the result, which may wait for the output register.
// Reset and start items clear every slot of the slot memory, and no item is
//   taken meanwhile. HASH_SLOTS must be a power of two; it is not checked.
// One item is in flight at a time; a result waits in the output register,
//   and the next item is taken while it waits.
`include "vertex_weld_hash_remap_unit_defines.svh"

module vertex_weld_hash_remap_unit import vwhr_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 16384,
  parameter int unsigned HASH_SLOTS   = 32768
) (
  input logic           clk_i,
  input logic           rst_ni,
  vwhr_in_if.sink       in_i,
  vwhr_out_if.source    out_o
);

  localparam int unsigned SW    = $clog2(HASH_SLOTS);
  localparam int unsigned PW    = $clog2(HASH_SLOTS + 1);
  localparam int unsigned AW    = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned LW    = (CNT_W > 14) ? CNT_W : 14;
  localparam int unsigned XW    = (AW > 14) ? AW : 14;

  typedef struct packed {
    logic          used;
    logic [31:0]   kx;
    logic [31:0]   ky;
    logic [31:0]   kz;
    logic [AW-1:0] idx;
  } slot_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PRD, S_PCHK,
    S_TRD0, S_TRD1, S_TRD2, S_TFIN, S_EMIT
  } state_e;

  function automatic logic [13:0] to14(input logic [AW-1:0] v);
    logic [XW-1:0] t;
    t = XW'(v);
    return t[13:0];
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [13:0] v);
    logic [LW-1:0] t;
    t = LW'(v);
    return t[AW-1:0];
  endfunction

  state_e        state_q;
  logic [SW-1:0] clr_q, slot_q;
  logic [PW-1:0] probes_q;
  logic [CNT_W-1:0] vseen_q, uniq_q;
  logic [31:0]   x_q, y_q, z_q;
  logic [13:0]   oa_q, ob_q, oc_q;
  logic [AW-1:0] ra_q, rb_q;
  logic          go_q;

  // pending result
  logic          rk_q, rnew_q;
  logic [13:0]   ridx_q, rta_q, rtb_q, rtc_q;
  logic [1:0]    rerr_q;

  // output register
  logic          ov_q, ok_q, onew_q;
  logic [13:0]   oidx_q, ota_q, otb_q, otc_q;
  logic [1:0]    oerr_q;

  // memories
  slot_t         slot_mem [HASH_SLOTS];
  logic [AW-1:0] remap_mem [MAX_VERTICES];
  slot_t         slot_rd_q;
  logic [AW-1:0] remap_rd_q;

  logic          slot_re, slot_we, remap_re, remap_we;
  logic [SW-1:0] slot_ra, slot_wa;
  slot_t         slot_wd;
  logic [AW-1:0] remap_ra, remap_wd;

  logic          in_acc, hash_done, out_free, key_hit, tri_bad, dropped;
  logic [SW-1:0] hash_slot, slot_next;
  logic [PW-1:0] probes_next;
  logic [AW-1:0] uniq_idx;
  hash_req_t     hreq;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !ov_q || out_o.ready;
  assign uniq_idx   = uniq_q[AW-1:0];
  assign key_hit    = (slot_rd_q.kx == x_q) && (slot_rd_q.ky == y_q) &&
                      (slot_rd_q.kz == z_q);
  assign slot_next  = (slot_q == SW'(HASH_SLOTS - 1)) ? '0 : slot_q + 1'b1;
  assign probes_next = probes_q + 1'b1;

  // a corner must be below the vertex count
  assign tri_bad = (LW'(in_i.old_a) >= LW'(vseen_q)) ||
                   (LW'(in_i.old_b) >= LW'(vseen_q)) ||
                   (LW'(in_i.old_c) >= LW'(vseen_q));

  // after any merge, a triangle with two equal corners is dropped
  assign dropped = (uniq_q < vseen_q) &&
                   ((ra_q == rb_q) || (rb_q == remap_rd_q) || (ra_q == remap_rd_q));

  assign hreq.go = go_q;
  assign hreq.x  = x_q;
  assign hreq.y  = y_q;
  assign hreq.z  = z_q;

  vwhr_hash #(.HASH_SLOTS(HASH_SLOTS)) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq),
    .done_o (hash_done),
    .slot_o (hash_slot)
  );

  // memory port control
  always_comb begin
    slot_re  = (state_q == S_PRD);
    slot_ra  = slot_q;
    slot_we  = 1'b0;
    slot_wa  = slot_q;
    slot_wd  = '0;
    remap_we = 1'b0;
    remap_wd = uniq_idx;
    remap_re = 1'b0;
    remap_ra = to_addr(oa_q);
    unique case (state_q)
      S_CLEAR: begin
        slot_we = 1'b1;
        slot_wa = clr_q;
      end
      S_PCHK: begin
        if (!slot_rd_q.used) begin
          slot_we  = 1'b1;
          slot_wd  = '{used: 1'b1, kx: x_q, ky: y_q, kz: z_q, idx: uniq_idx};
          remap_we = 1'b1;
        end else if (key_hit) begin
          remap_we = 1'b1;
          remap_wd = slot_rd_q.idx;
        end
      end
      S_TRD0: remap_re = 1'b1;
      S_TRD1: begin
        remap_re = 1'b1;
        remap_ra = to_addr(ob_q);
      end
      S_TRD2: begin
        remap_re = 1'b1;
        remap_ra = to_addr(oc_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) slot_rd_q <= slot_mem[slot_ra];
    if (remap_we) remap_mem[vseen_q[AW-1:0]] <= remap_wd;
    if (remap_re) remap_rd_q <= remap_mem[remap_ra];
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q  <= in_i.cell_x;
      y_q  <= in_i.cell_y;
      z_q  <= in_i.cell_z;
      oa_q <= in_i.old_a;
      ob_q <= in_i.old_b;
      oc_q <= in_i.old_c;
    end
    if (state_q == S_TRD1) ra_q <= remap_rd_q;
    if (state_q == S_TRD2) rb_q <= remap_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      slot_q   <= '0;
      probes_q <= '0;
      vseen_q  <= '0;
      uniq_q   <= '0;
      go_q     <= 1'b0;
      rk_q     <= KIND_VERTEX;
      rnew_q   <= 1'b0;
      ridx_q   <= '0;
      rta_q    <= '0;
      rtb_q    <= '0;
      rtc_q    <= '0;
      rerr_q   <= ERR_NONE;
      ov_q     <= 1'b0;
      ok_q     <= KIND_VERTEX;
      onew_q   <= 1'b0;
      oidx_q   <= '0;
      ota_q    <= '0;
      otb_q    <= '0;
      otc_q    <= '0;
      oerr_q   <= ERR_NONE;
    end else begin
      go_q <= 1'b0;
      // a beat that is emitted reloads the register instead
      if (ov_q && out_o.ready && (state_q != S_EMIT)) ov_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          if (clr_q == SW'(HASH_SLOTS - 1)) begin
            clr_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            rnew_q <= 1'b0;
            ridx_q <= '0;
            rta_q  <= '0;
            rtb_q  <= '0;
            rtc_q  <= '0;
            rerr_q <= ERR_NONE;
            unique case (in_i.mode)
              MODE_VERTEX: begin
                rk_q <= KIND_VERTEX;
                if (vseen_q == CNT_W'(MAX_VERTICES)) begin
                  rerr_q  <= ERR_FULL;
                  state_q <= S_EMIT;
                end else begin
                  go_q    <= 1'b1;
                  state_q <= S_HASH;
                end
              end
              MODE_TRIANGLE: begin
                rk_q <= KIND_TRI;
                if (tri_bad) begin
                  rerr_q  <= ERR_UNSEEN;
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_TRD0;
                end
              end
              MODE_START: begin
                vseen_q <= '0;
                uniq_q  <= '0;
                clr_q   <= '0;
                state_q <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_HASH: begin
          if (hash_done) begin
            slot_q   <= hash_slot;
            probes_q <= '0;
            state_q  <= S_PRD;
          end
        end
        S_PRD: state_q <= S_PCHK;
        S_PCHK: begin
          if (!slot_rd_q.used) begin
            ridx_q  <= to14(uniq_idx);
            rnew_q  <= 1'b1;
            vseen_q <= vseen_q + 1'b1;
            uniq_q  <= uniq_q + 1'b1;
            state_q <= S_EMIT;
          end else if (key_hit) begin
            ridx_q  <= to14(slot_rd_q.idx);
            vseen_q <= vseen_q + 1'b1;
            state_q <= S_EMIT;
          end else if (probes_next == PW'(HASH_SLOTS)) begin
            rerr_q  <= ERR_FULL;
            state_q <= S_EMIT;
          end else begin
            probes_q <= probes_next;
            slot_q   <= slot_next;
            state_q  <= S_PRD;
          end
        end
        S_TRD0: state_q <= S_TRD1;
        S_TRD1: state_q <= S_TRD2;
        S_TRD2: state_q <= S_TFIN;
        S_TFIN: begin
          if (dropped) begin
            state_q <= S_IDLE;
          end else begin
            rta_q   <= to14(ra_q);
            rtb_q   <= to14(rb_q);
            rtc_q   <= to14(remap_rd_q);
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            ov_q    <= 1'b1;
            ok_q    <= rk_q;
            onew_q  <= rnew_q;
            oidx_q  <= ridx_q;
            ota_q   <= rta_q;
            otb_q   <= rtb_q;
            otc_q   <= rtc_q;
            oerr_q  <= rerr_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.result_kind = ok_q;
  assign out_o.new_index   = oidx_q;
  assign out_o.is_new      = onew_q;
  assign out_o.tri_a       = ota_q;
  assign out_o.tri_b       = otb_q;
  assign out_o.tri_c       = otc_q;
  assign out_o.error       = oerr_q;

  `VWHR_ASSERT(a_cnt_order, 1'b1, uniq_q <= vseen_q, "unique count above vertex count")
  `VWHR_ASSERT(a_cnt_cap, 1'b1, vseen_q <= CNT_W'(MAX_VERTICES), "vertex count over capacity")
  `VWHR_ASSERT(a_hash_done, hash_done, state_q == S_HASH, "hash done outside hash wait")
  `VWHR_ASSERT_NEXT(a_start_clr, in_acc && (in_i.mode == MODE_START), (state_q == S_CLEAR) && (vseen_q == '0), "start did not clear")

endmodule

@@ rtl/vwhr_hash.sv @@
// Cell hash: multiply-xor mix, then the low bits give the slot (HASH_SLOTS must
// be a power of two; it is not checked). Depends on vwhr_pkg.
module vwhr_hash import vwhr_pkg::*; #(
  parameter int unsigned HASH_SLOTS = 32768
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hash_req_t                     req_i,
  output logic                          done_o,
  output logic [$clog2(HASH_SLOTS)-1:0] slot_o
);

  localparam int unsigned SW = $clog2(HASH_SLOTS);

  typedef enum logic [1:0] {H_IDLE, H_MIX, H_MUL, H_FOLD} hstate_e;

  hstate_e       state_q;
  logic [31:0]   px_q, py_q, pz_q, h_q, m_q;
  logic [SW-1:0] r_q;
  logic          done_q;
  logic [31:0]   mix, fold;

  always_comb begin
    logic [31:0] t;
    t   = px_q ^ py_q;
    t   = {t[24:0], t[31:25]};
    t   = t ^ pz_q;
    mix = t ^ (t >> 15);
  end

  // remainder by a power of two is the low bits
  assign fold = m_q ^ (m_q >> 13);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        H_IDLE: if (req_i.go) state_q <= H_MIX;
        H_MIX:  state_q <= H_MUL;
        H_MUL:  state_q <= H_FOLD;
        H_FOLD: begin
          done_q  <= 1'b1;
          state_q <= H_IDLE;
        end
        default: state_q <= H_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == H_IDLE) begin
      px_q <= req_i.x * HASH_KX;
      py_q <= req_i.y * HASH_KY;
      pz_q <= req_i.z * HASH_KZ;
    end
    if (state_q == H_MIX) h_q <= mix;
    if (state_q == H_MUL) m_q <= h_q * HASH_FIN;
    if (state_q == H_FOLD) r_q <= fold[SW-1:0];
  end

  assign done_o = done_q;
  assign slot_o = r_q;

endmodule
